### rtl/core/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types, character codes and helper functions for the radix string
// to integer parser.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int unsigned VALUE_BITS_DEFAULT = 64;
    localparam int unsigned RADIX_W            = 6;
    localparam int unsigned DIGIT_W            = 6;
    localparam int unsigned MAG_W              = 64;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_BAD   = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_CASE  = 8'h20;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

    typedef enum logic [2:0] {
        PH_WS        = 3'd0,
        PH_SIGNED    = 3'd1,
        PH_LEAD_ZERO = 3'd2,
        PH_PREFIX    = 3'd3,
        PH_DIGITS    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ok;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // digit value, or DIGIT_NONE for a byte that is no digit in any base
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'(DIGIT_NONE);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d = c - CH_LO_A + 8'd10;
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d = c - CH_UP_A + 8'd10;
        end
        return d[DIGIT_W-1:0];
    endfunction

endpackage

### rtl/core/radix_string_to_integer.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer
// Streaming strtoll-style parser: one byte per item, one result per string.
// ----------------------------------------------------------------------------
// the result of a last byte is shown once that byte has passed the input
//   register, then the result register
// throughput: one byte per cycle while no last byte waits on a stalled result,
//   set by the single multiply-add by the base that updates the running magnitude
// reset: parser state back to the whitespace phase, radix register to 10,
//   both item registers empty
module radix_string_to_integer #(
    parameter int unsigned VALUE_BITS = rsi_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // byte stream
    input  logic                         item_valid,
    output logic                         item_stall,
    input  rsi_pkg::item_t               item,
    // parsed result
    output logic                         result_valid,
    input  logic                         result_stall,
    output rsi_pkg::result_t             result,
    // radix register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rsi_pkg::RADIX_W-1:0]  cfg_radix
);

    localparam int unsigned PROD_W = rsi_pkg::MAG_W + rsi_pkg::RADIX_W;

    // configuration
    logic [rsi_pkg::RADIX_W-1:0] radix_reg;

    // input register
    logic           in_valid_reg, in_valid_next;
    rsi_pkg::item_t in_reg;

    // parser state
    rsi_pkg::phase_t              phase_reg, phase_next;
    logic                         neg_reg, neg_next;
    logic [rsi_pkg::MAG_W-1:0]    mag_reg, mag_next;
    logic                         ovf_reg, ovf_next;
    logic [rsi_pkg::RADIX_W-1:0]  base_reg, base_next;
    logic                         rej_reg, rej_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    rsi_pkg::result_t out_reg, out_next;

    // handshake
    logic accept;
    logic out_free;
    logic process;

    // datapath
    logic [7:0]                   c;
    logic [rsi_pkg::DIGIT_W-1:0]  digit;
    logic [rsi_pkg::RADIX_W-1:0]  start_base;
    logic [rsi_pkg::RADIX_W-1:0]  add_base;
    logic                         do_add;
    logic [PROD_W-1:0]            prod;
    logic                         ok;
    logic [63:0]                  signed_val;
    logic [63:0]                  ext_val;

    // cfg_ready stays high; write the radix register only while idle, which is not enforced
    assign cfg_ready = 1'b1;

    // ---------------- handshake ----------------
    // a last byte needs room in the result register, other bytes go straight
    assign out_free   = !out_valid_reg || !result_stall;
    assign process    = in_valid_reg && (!in_reg.last || out_free);
    assign item_stall = in_valid_reg && !process;
    assign accept     = item_valid && !item_stall;

    assign in_valid_next = accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);

    // ---------------- per-byte parse ----------------
    assign c     = in_reg.ch;
    assign digit = rsi_pkg::digit_of(c);

    // base a first digit is read in: radix sampled here in the whitespace phase
    assign start_base = (phase_reg == rsi_pkg::PH_WS) ? radix_reg : base_reg;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        base_next  = base_reg;
        rej_next   = rej_reg;
        add_base   = base_reg;
        do_add     = 1'b0;
        prod       = '0;

        if (!rej_reg)
        begin
            case (phase_reg)
                rsi_pkg::PH_WS,
                rsi_pkg::PH_SIGNED:
                begin
                    if (phase_reg == rsi_pkg::PH_WS && rsi_pkg::is_space(c))
                    begin
                        // still in leading whitespace
                    end
                    else if (phase_reg == rsi_pkg::PH_WS &&
                             (radix_reg == rsi_pkg::RADIX_BAD ||
                              radix_reg > rsi_pkg::RADIX_MAX))
                    begin
                        rej_next = 1'b1;
                    end
                    else if (phase_reg == rsi_pkg::PH_WS && c == rsi_pkg::CH_PLUS)
                    begin
                        base_next  = radix_reg;
                        phase_next = rsi_pkg::PH_SIGNED;
                    end
                    else if (phase_reg == rsi_pkg::PH_WS && c == rsi_pkg::CH_MINUS)
                    begin
                        base_next  = radix_reg;
                        neg_next   = 1'b1;
                        phase_next = rsi_pkg::PH_SIGNED;
                    end
                    else
                    begin
                        // first byte of the digit run
                        base_next = start_base;
                        if (start_base == rsi_pkg::RADIX_AUTO)
                        begin
                            if (c == rsi_pkg::CH_ZERO)
                            begin
                                base_next  = rsi_pkg::BASE_OCT;
                                phase_next = rsi_pkg::PH_LEAD_ZERO;
                            end
                            else
                            begin
                                base_next = rsi_pkg::BASE_DEC;
                                add_base  = rsi_pkg::BASE_DEC;
                                do_add    = 1'b1;
                            end
                        end
                        else if (start_base == rsi_pkg::BASE_HEX &&
                                 c == rsi_pkg::CH_ZERO)
                        begin
                            phase_next = rsi_pkg::PH_LEAD_ZERO;
                        end
                        else
                        begin
                            add_base = start_base;
                            do_add   = 1'b1;
                        end
                    end
                end
                rsi_pkg::PH_LEAD_ZERO:
                begin
                    if ((c | rsi_pkg::CH_CASE) == rsi_pkg::CH_LO_X)
                    begin
                        base_next  = rsi_pkg::BASE_HEX;
                        phase_next = rsi_pkg::PH_PREFIX;
                    end
                    else
                    begin
                        do_add = 1'b1;
                    end
                end
                rsi_pkg::PH_PREFIX,
                rsi_pkg::PH_DIGITS:
                begin
                    do_add = 1'b1;
                end
                default:
                begin
                    rej_next = 1'b1;
                end
            endcase

            // one shared multiply-add by the effective base
            prod = PROD_W'(mag_reg) * PROD_W'(add_base) + PROD_W'(digit);

            if (do_add)
            begin
                if (add_base < rsi_pkg::BASE_MIN || digit >= add_base)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    // a carry out of 64 bits is an overflow; magnitude then holds
                    if (prod[PROD_W-1:rsi_pkg::MAG_W] != '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = prod[rsi_pkg::MAG_W-1:0];
                    end
                    phase_next = rsi_pkg::PH_DIGITS;
                end
            end
        end
    end

    // ---------------- result on the last byte ----------------
    // in range: below 2^63, or exactly 2^63 when negative
    assign ok = !rej_next && !ovf_next &&
                (phase_next == rsi_pkg::PH_DIGITS || phase_next == rsi_pkg::PH_LEAD_ZERO) &&
                (!mag_next[63] || (neg_next && mag_next[62:0] == '0));

    assign signed_val = neg_next ? (64'd0 - mag_next) : mag_next;

    // keep the low VALUE_BITS bits, sign-extended
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            ext_val[i] = (i < VALUE_BITS) ? signed_val[i] : signed_val[VALUE_BITS-1];
        end
    end

    always_comb
    begin
        out_next.value = ok ? ext_val : 64'd0;
        out_next.ok    = ok;
    end

    always_comb
    begin
        if (process && in_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rsi_pkg::RADIX_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= rsi_pkg::PH_WS;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
            base_reg      <= '0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                radix_reg <= cfg_radix;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
            begin
                if (in_reg.last)
                begin
                    // string done: back to the start state, radix kept
                    phase_reg <= rsi_pkg::PH_WS;
                    neg_reg   <= 1'b0;
                    mag_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    base_reg  <= '0;
                    rej_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    ovf_reg   <= ovf_next;
                    base_reg  <= base_next;
                    rej_reg   <= rej_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (process && in_reg.last)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### tb/sv/radix_string_to_integer_test.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer_test
// Streams strings byte by byte into the parser under random idling on both
// sides. A local strtoll-style predictor works out the number and ok flag of
// every string, and each result leaving the block is checked against the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module radix_string_to_integer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_BITS  = rsi_pkg::VALUE_BITS_DEFAULT;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PHASE_BYTES = 65;

    // byte codes not given by the package
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_HIGH = 8'hFF;
    localparam logic [7:0] CH_UP_X = rsi_pkg::CH_LO_X ^ rsi_pkg::CH_CASE;

    // radix settings outside the legal range
    localparam logic [rsi_pkg::RADIX_W-1:0] RADIX_PAST = rsi_pkg::RADIX_MAX + 6'd1;
    localparam logic [rsi_pkg::RADIX_W-1:0] RADIX_TOP  = '1;

    typedef logic [7:0] text_t[$];

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_stall;
    rsi_pkg::item_t              item;
    logic                        result_valid;
    logic                        result_stall;
    rsi_pkg::result_t            result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [rsi_pkg::RADIX_W-1:0] cfg_radix;

    // predictor state, one string at a time
    logic [rsi_pkg::RADIX_W-1:0] cur_radix;
    rsi_pkg::phase_t             parse_phase;
    logic                        is_negative;
    logic [63:0]                 magnitude_acc;
    logic                        mag_overflow;
    logic [rsi_pkg::RADIX_W-1:0] digit_base;
    logic                        string_rejected;

    // numbers predicted for strings whose last byte has gone in
    rsi_pkg::result_t parsed_values[$];
    rsi_pkg::result_t oldest;

    int  error_count;
    int  cycle_count;
    int  bytes_sent;
    // when set, neither side idles
    bit  steady;

    radix_string_to_integer #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_radix    (cfg_radix)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int digit_value(input logic [7:0] c);
        if (c >= rsi_pkg::CH_ZERO && c <= rsi_pkg::CH_NINE)
        begin
            return int'(c - rsi_pkg::CH_ZERO);
        end
        if (c >= rsi_pkg::CH_LO_A && c <= rsi_pkg::CH_LO_Z)
        begin
            return int'(c - rsi_pkg::CH_LO_A) + 10;
        end
        if (c >= rsi_pkg::CH_UP_A && c <= rsi_pkg::CH_UP_Z)
        begin
            return int'(c - rsi_pkg::CH_UP_A) + 10;
        end
        return 36;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return (c == rsi_pkg::CH_SPACE) || (c >= rsi_pkg::CH_TAB && c <= rsi_pkg::CH_CR);
    endfunction

    task automatic clear_parse();
        parse_phase     = rsi_pkg::PH_WS;
        is_negative     = 1'b0;
        magnitude_acc   = '0;
        mag_overflow    = 1'b0;
        digit_base      = '0;
        string_rejected = 1'b0;
    endtask

    // multiply-add one digit, flagging a wrap past 64 bits unsigned
    task automatic take_digit(input logic [7:0] c);
        int          d;
        logic [63:0] headroom;
        d = digit_value(c);
        if (digit_base < rsi_pkg::BASE_MIN || d >= int'(digit_base))
        begin
            string_rejected = 1'b1;
            return;
        end
        headroom = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(digit_base);
        if (magnitude_acc > headroom)
        begin
            mag_overflow = 1'b1;
        end
        else
        begin
            magnitude_acc = magnitude_acc * 64'(digit_base) + 64'(d);
        end
        parse_phase = rsi_pkg::PH_DIGITS;
    endtask

    // first byte of the digit run, after any sign: auto radix and the hex prefix start here
    task automatic first_digit(input logic [7:0] c);
        if (digit_base == rsi_pkg::RADIX_AUTO)
        begin
            if (c == rsi_pkg::CH_ZERO)
            begin
                digit_base  = rsi_pkg::BASE_OCT;
                parse_phase = rsi_pkg::PH_LEAD_ZERO;
                return;
            end
            digit_base = rsi_pkg::BASE_DEC;
        end
        else if (digit_base == rsi_pkg::BASE_HEX && c == rsi_pkg::CH_ZERO)
        begin
            parse_phase = rsi_pkg::PH_LEAD_ZERO;
            return;
        end
        take_digit(c);
    endtask

    task automatic consume_char(input logic [7:0] c);
        case (parse_phase)
            rsi_pkg::PH_WS:
            begin
                if (blank_char(c))
                begin
                    return;
                end
                // radix is sampled where the leading blanks end
                if (cur_radix == rsi_pkg::RADIX_BAD || cur_radix > rsi_pkg::RADIX_MAX)
                begin
                    string_rejected = 1'b1;
                    return;
                end
                digit_base = cur_radix;
                if (c == rsi_pkg::CH_PLUS)
                begin
                    parse_phase = rsi_pkg::PH_SIGNED;
                end
                else if (c == rsi_pkg::CH_MINUS)
                begin
                    is_negative = 1'b1;
                    parse_phase = rsi_pkg::PH_SIGNED;
                end
                else
                begin
                    first_digit(c);
                end
            end
            rsi_pkg::PH_SIGNED:
            begin
                first_digit(c);
            end
            rsi_pkg::PH_LEAD_ZERO:
            begin
                if ((c | rsi_pkg::CH_CASE) == rsi_pkg::CH_LO_X)
                begin
                    digit_base  = rsi_pkg::BASE_HEX;
                    parse_phase = rsi_pkg::PH_PREFIX;
                end
                else
                begin
                    take_digit(c);
                end
            end
            rsi_pkg::PH_PREFIX, rsi_pkg::PH_DIGITS:
            begin
                take_digit(c);
            end
            default:
            begin
                string_rejected = 1'b1;
            end
        endcase
    endtask

    // one accepted byte; the last byte of a string yields its number
    task automatic parse_byte(input logic [7:0] c, input logic last);
        logic [63:0]        bound;
        logic [63:0]        v;
        logic signed [63:0] sv;
        bit                 ok;
        rsi_pkg::result_t   r;
        if (!string_rejected)
        begin
            consume_char(c);
        end
        if (!last)
        begin
            return;
        end
        bound = is_negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        ok = !string_rejected && !mag_overflow &&
             (parse_phase == rsi_pkg::PH_DIGITS || parse_phase == rsi_pkg::PH_LEAD_ZERO) &&
             magnitude_acc <= bound;
        v = '0;
        if (ok)
        begin
            v  = is_negative ? 64'd0 - magnitude_acc : magnitude_acc;
            // narrow to the value width, sign extended
            sv = v << (64 - VALUE_BITS);
            sv = sv >>> (64 - VALUE_BITS);
            v  = sv;
        end
        r.value = v;
        r.ok    = ok;
        parsed_values.push_back(r);
        clear_parse();
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch (%s): got %h, expected %h at %0t ns", what, got, want, $time);
    endtask

    // every result handed over is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (parsed_values.size() == 0)
            begin
                report_mismatch("result with none pending", result.value, '0);
            end
            else
            begin
                oldest = parsed_values.pop_front();
                if (result.value !== oldest.value)
                begin
                    report_mismatch("value", result.value, oldest.value);
                end
                if (result.ok !== oldest.ok)
                begin
                    report_mismatch("ok", 64'(result.ok), 64'(oldest.ok));
                end
            end
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: a random stall before each result, none while steady is set
    initial
    begin
        int hold;
        result_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 7);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!result_valid);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // valid is left high after acceptance so that a gap-free next item
    // follows in the very next cycle
    task automatic send_byte(input logic [7:0] c, input logic last);
        int             gap;
        rsi_pkg::item_t next_item;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        next_item.ch   = c;
        next_item.last = last;
        item_valid <= 1'b1;
        item       <= next_item;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        parse_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_bytes(input text_t q);
        for (int i = 0; i < q.size(); i++)
        begin
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        text_t q;
        for (int i = 0; i < s.len(); i++)
        begin
            q.push_back(s[i]);
        end
        send_bytes(q);
    endtask

    // stream stopped and every pending number out before anything else
    task automatic drain();
        item_valid <= 1'b0;
        while (parsed_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_radix(input logic [rsi_pkg::RADIX_W-1:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_radix <= r;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_radix = r;
    endtask

    // digits of mag in the given base, most significant first
    task automatic append_digits(ref text_t q, input logic [63:0] mag, input int base,
                                 input bit upper);
        text_t digits;
        int    d;
        do
        begin
            d   = int'(mag % 64'(base));
            mag = mag / 64'(base);
            digits.push_front(d < 10 ? rsi_pkg::CH_ZERO + 8'(d)
                                     : (upper ? rsi_pkg::CH_UP_A : rsi_pkg::CH_LO_A)
                                       + 8'(d - 10));
        end
        while (mag != 0);
        foreach (digits[i])
        begin
            q.push_back(digits[i]);
        end
    endtask

    // mostly well-formed numbers with random content, some broken, some noise
    task automatic make_string(ref text_t q);
        int          kind;
        int          base;
        logic [63:0] mag;
        bit          upper;
        q.delete();
        kind  = $urandom_range(0, 9);
        upper = $urandom_range(0, 1);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                q.push_back($urandom_range(0, 5) == 5
                            ? rsi_pkg::CH_SPACE
                            : rsi_pkg::CH_TAB + 8'($urandom_range(0, 4)));
            end
        end
        case ($urandom_range(0, 3))
            0: q.push_back(rsi_pkg::CH_PLUS);
            1: q.push_back(rsi_pkg::CH_MINUS);
            default: ;
        endcase
        base = int'(cur_radix);
        if (cur_radix == rsi_pkg::RADIX_AUTO)
        begin
            case ($urandom_range(0, 2))
                0: base = 8;
                1: base = 10;
                default: base = 16;
            endcase
            if (base != 10)
            begin
                q.push_back(rsi_pkg::CH_ZERO);
            end
            if (base == 16)
            begin
                q.push_back(upper ? CH_UP_X : rsi_pkg::CH_LO_X);
            end
        end
        else if (cur_radix == rsi_pkg::BASE_HEX && $urandom_range(0, 1) == 1)
        begin
            q.push_back(rsi_pkg::CH_ZERO);
            q.push_back(upper ? CH_UP_X : rsi_pkg::CH_LO_X);
        end
        else if (cur_radix == rsi_pkg::RADIX_BAD || cur_radix > rsi_pkg::RADIX_MAX)
        begin
            base = 10;
        end
        // small values, around the signed limits, at the unsigned wrap, or random width
        case ($urandom_range(0, 5))
            0: mag = 64'($urandom_range(0, 99));
            1: mag = 64'h8000_0000_0000_0000 - 64'd2 + 64'($urandom_range(0, 3));
            2: mag = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1));
            default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 2)) q.push_back(rsi_pkg::CH_ZERO);
        end
        append_digits(q, mag, base, upper);
        if (kind == 7)
        begin
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (kind == 8)
        begin
            q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // radix left at its reset value of ten
    task automatic test_decimal_at_reset();
        send_text("0");
        send_text("+7");
        send_text("-12");
        send_text("007");
        // every blank kind ahead of the digits
        send_text(" \011\012\013\014\01542");
    endtask

    task automatic test_malformed_strings();
        send_text("   ");
        send_text("-");
        send_text("+-1");
        send_text("12 ");
        send_text("1a");
        send_bytes('{8'h31, CH_NUL});
        send_bytes('{CH_NUL});
        send_bytes('{CH_HIGH});
    endtask

    task automatic test_hex_and_auto_prefixes();
        write_radix(rsi_pkg::BASE_HEX);
        send_text("0x1F");
        send_text("0XaB");
        send_text("0x");
        send_text("0");
        send_text("-0x10");
        send_text("x1");
        write_radix(rsi_pkg::RADIX_AUTO);
        send_text("0x7f");
        send_text("017");
        send_text("08");
        send_text("-19");
        send_text("0");
    endtask

    task automatic test_radix_extremes();
        write_radix(rsi_pkg::BASE_MIN);
        send_text("101");
        send_text("2");
        write_radix(rsi_pkg::RADIX_MAX);
        send_text("zZ");
        send_text("-Zz");
        write_radix(rsi_pkg::RADIX_BAD);
        send_text("1");
        write_radix(RADIX_TOP);
        send_text("1");
        write_radix(RADIX_PAST);
        send_text("0");
    endtask

    task automatic test_range_limits();
        write_radix(rsi_pkg::BASE_DEC);
        send_text("9223372036854775807");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("-9223372036854775809");
        send_text("99999999999999999999");
        write_radix(rsi_pkg::BASE_HEX);
        send_text("-8000000000000000");
        send_text("10000000000000000");
    endtask

    // random strings over a sweep of radix settings
    task automatic test_random_strings();
        text_t                       q;
        logic [rsi_pkg::RADIX_W-1:0] r;
        int                          start;
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: r = rsi_pkg::BASE_DEC;
                1: r = rsi_pkg::RADIX_AUTO;
                2: r = rsi_pkg::BASE_HEX;
                3: r = rsi_pkg::BASE_MIN;
                4: r = rsi_pkg::RADIX_MAX;
                5: r = rsi_pkg::BASE_OCT;
                6: r = rsi_pkg::RADIX_BAD;
                7: r = RADIX_TOP;
                default: r = rsi_pkg::RADIX_W'($urandom_range(2, 36));
            endcase
            steady = 1'b0;
            write_radix(r);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                // now and then a stretch with no idling on either side
                steady = ($urandom_range(0, 4) == 0);
                make_string(q);
                send_bytes(q);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        bytes_sent  = 0;
        steady      = 1'b0;
        cur_radix   = rsi_pkg::RADIX_RESET;
        clear_parse();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_radix  <= rsi_pkg::RADIX_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_decimal_at_reset();
        test_malformed_strings();
        test_hex_and_auto_prefixes();
        test_radix_extremes();
        test_range_limits();
        test_random_strings();

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/rsi_pkg.sv
rtl/core/radix_string_to_integer.sv
tb/sv/radix_string_to_integer_test.sv
